>>> rtl/core/protobuf_top_level_field_framer_core_macros.svh
// ---------------------------------------------------------------------------
// Protobuf framer assertion macros
// Shared concurrent assertion forms for the framer core modules.
// ---------------------------------------------------------------------------
`ifndef PROTOBUF_TOP_LEVEL_FIELD_FRAMER_CORE_MACROS_SVH
`define PROTOBUF_TOP_LEVEL_FIELD_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PBFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PBFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pbfr_pkg.sv
// ---------------------------------------------------------------------------
// Protobuf framer package
// Types and codes shared by the framer core modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pbfr_pkg;

   typedef enum logic [2:0] {
      PH_TAG = 3'd0,
      PH_LEN = 3'd1,
      PH_HDR = 3'd2,
      PH_ENT = 3'd3,
      PH_SKV = 3'd4,
      PH_SKF = 3'd5
   } phase_type;

   // byte classes
   localparam logic [2:0] CLS_TAG     = 3'd0;
   localparam logic [2:0] CLS_LEN     = 3'd1;
   localparam logic [2:0] CLS_HDR     = 3'd2;
   localparam logic [2:0] CLS_ENT     = 3'd3;
   localparam logic [2:0] CLS_SKV     = 3'd4;
   localparam logic [2:0] CLS_SKF     = 3'd5;
   localparam logic [2:0] CLS_IGNORED = 3'd6;

   // feed status
   localparam logic [1:0] ST_COMPLETE  = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_MALFORMED = 2'd2;

   // wire types
   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_I64    = 3'd1;
   localparam logic [2:0] WT_LEN    = 3'd2;
   localparam logic [2:0] WT_I32    = 3'd5;

   localparam logic [31:0] FIELD_HEADER = 32'd1;
   localparam logic [31:0] FIELD_ENTITY = 32'd2;

   // CSR map
   localparam logic CSR_MAX_ENTITY = 1'b0;
   localparam logic CSR_MAX_HEADER = 1'b1;

   localparam int MAX_ENTITY_W = 20;
   localparam int MAX_HEADER_W = 16;
   localparam logic [MAX_ENTITY_W-1:0] MAX_ENTITY_RST = 20'd4096;
   localparam logic [MAX_HEADER_W-1:0] MAX_HEADER_RST = 16'd256;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  data_byte_out;
      logic [31:0] field_number;
      logic        body_last;
      logic        body_empty;
      logic        entity_start;
      logic        entity_too_large;
      logic [1:0]  feed_status;
      logic [31:0] entities_seen;
      logic [31:0] entities_too_large;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/protobuf_top_level_field_framer_core.sv
// ---------------------------------------------------------------------------
// Protobuf top-level field framer core
// Walks a protobuf wire-format feed one byte per transaction and tags bytes.
// ---------------------------------------------------------------------------
// Takes one feed byte per cycle while the output buffer has room and returns
// one registered result per byte. Every byte goes through a single
// register-to-register pass: tag and length varints are built up seven bits at
// a time, header (field 1) and entity (field 2) bodies are echoed with a
// last-byte mark, and everything else is skipped. A two-entry output buffer
// lets the input keep accepting while one result waits; the input stalls only
// once both entries are full. The limit registers may be written only while no
// byte is in flight. A malformed feed is sticky until reset.
`default_nettype none

module protobuf_top_level_field_framer_core (
   input  wire logic          clock,
   input  wire logic          reset,
   // feed input
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] data_byte
   // result output
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [7:0] data_byte_out, [39:8] field_number, [40] body_empty,
   // [41] entity_start, [42] entity_too_large, [44:43] feed_status,
   // [76:45] entities_seen, [108:77] entities_too_large, [111:109] zero
   output logic [111:0]       rsp_tdata,
   output logic [2:0]         rsp_tuser,   // [2:0] byte_class
   output logic               rsp_tlast,   // body_last
   // configuration
   input  wire logic          csr_we,
   input  wire logic          csr_addr,
   input  wire logic [pbfr_pkg::MAX_ENTITY_W-1:0] csr_wdata
);
   import pbfr_pkg::*;

   logic [MAX_ENTITY_W-1:0] max_entity_ff;
   logic [MAX_HEADER_W-1:0] max_header_ff;
   logic                    take;
   result_type              step_res;
   result_type              rsp_res;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entity_ff <= MAX_ENTITY_RST;
         max_header_ff <= MAX_HEADER_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_ENTITY: max_entity_ff <= csr_wdata;
            CSR_MAX_HEADER: max_header_ff <= csr_wdata[MAX_HEADER_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the framing state on every accepted transaction
   assign take = req_tvalid && req_tready;

   pbfr_step u_step (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_tdata),
      .max_entity (max_entity_ff),
      .max_header (max_header_ff),
      .result     (step_res)
   );

   pbfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_ready  (req_tready),
      .in_data   (step_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   // Pack the result onto the stream fields
   assign rsp_tuser = rsp_res.byte_class;
   assign rsp_tlast = rsp_res.body_last;
   assign rsp_tdata = {3'b000,
                       rsp_res.entities_too_large,
                       rsp_res.entities_seen,
                       rsp_res.feed_status,
                       rsp_res.entity_too_large,
                       rsp_res.entity_start,
                       rsp_res.body_empty,
                       rsp_res.field_number,
                       rsp_res.data_byte_out};

endmodule

`default_nettype wire

>>> rtl/core/pbfr_step.sv
// ---------------------------------------------------------------------------
// Protobuf framer step
// Framing state registers and the per-byte next-state and result logic.
// ---------------------------------------------------------------------------
`default_nettype none
`include "protobuf_top_level_field_framer_core_macros.svh"

module pbfr_step (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               take,
   input  wire logic [7:0]                         data_byte,
   input  wire logic [pbfr_pkg::MAX_ENTITY_W-1:0]  max_entity,
   input  wire logic [pbfr_pkg::MAX_HEADER_W-1:0]  max_header,
   output pbfr_pkg::result_type                    result
);
   import pbfr_pkg::*;

   localparam logic [3:0] VCNT_LAST = 4'd9;   // last group that still lands below bit 64
   localparam logic [3:0] VCNT_OVER = 4'd10;  // shift of 70: overlong

   phase_type   phase_ff, phase_in;
   logic [63:0] accum_ff, accum_in;
   logic [3:0]  vcnt_ff, vcnt_in;
   logic [31:0] field_ff, field_in;
   logic [63:0] remain_ff, remain_in;
   logic        error_ff, error_in;
   logic [31:0] seen_ff, seen_in;
   logic [31:0] tl_ff, tl_in;

   logic [6:0]  shamt;
   logic [63:0] acc_new;
   logic [3:0]  vcnt_inc;
   logic        more;

   assign shamt    = {vcnt_ff, 3'b000} - {3'b000, vcnt_ff};
   assign acc_new  = (vcnt_ff <= VCNT_LAST) ?
                     (accum_ff | ({57'd0, data_byte[6:0]} << shamt)) : accum_ff;
   assign vcnt_inc = vcnt_ff + 4'd1;
   assign more     = data_byte[7];

   always_comb begin
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      vcnt_in   = vcnt_ff;
      field_in  = field_ff;
      remain_in = remain_ff;
      error_in  = error_ff;
      seen_in   = seen_ff;
      tl_in     = tl_ff;
      result    = '0;
      result.byte_class = CLS_IGNORED;

      if (!error_ff) begin
         case (phase_ff)
            PH_LEN: begin
               result.byte_class = CLS_LEN;
               if (more) begin
                  accum_in = acc_new;
                  vcnt_in  = vcnt_inc;
                  if (vcnt_inc == VCNT_OVER) begin
                     error_in = 1'b1;
                  end
               end else begin
                  accum_in  = '0;
                  vcnt_in   = '0;
                  remain_in = acc_new;
                  if (field_ff == FIELD_HEADER) begin
                     if (acc_new == 64'd0) begin
                        result.body_last  = 1'b1;
                        result.body_empty = 1'b1;
                        phase_in          = PH_TAG;
                     end else if (acc_new > {48'd0, max_header}) begin
                        phase_in = PH_SKF;
                     end else begin
                        phase_in = PH_HDR;
                     end
                  end else if (field_ff == FIELD_ENTITY) begin
                     seen_in             = seen_ff + 32'd1;
                     result.entity_start = 1'b1;
                     if (acc_new > {44'd0, max_entity}) begin
                        tl_in                   = tl_ff + 32'd1;
                        result.entity_too_large = 1'b1;
                        phase_in                = PH_SKF;
                     end else if (acc_new == 64'd0) begin
                        result.body_last  = 1'b1;
                        result.body_empty = 1'b1;
                        phase_in          = PH_TAG;
                     end else begin
                        phase_in = PH_ENT;
                     end
                  end else if (acc_new == 64'd0) begin
                     phase_in = PH_TAG;
                  end else begin
                     phase_in = PH_SKF;
                  end
               end
            end
            PH_HDR, PH_ENT: begin
               result.byte_class    = (phase_ff == PH_HDR) ? CLS_HDR : CLS_ENT;
               result.data_byte_out = data_byte;
               remain_in            = remain_ff - 64'd1;
               if (remain_ff == 64'd1) begin
                  result.body_last = 1'b1;
                  phase_in         = PH_TAG;
               end
            end
            PH_SKV: begin
               result.byte_class = CLS_SKV;
               if (!more) begin
                  phase_in = PH_TAG;
               end
            end
            PH_SKF: begin
               result.byte_class = CLS_SKF;
               remain_in         = remain_ff - 64'd1;
               if (remain_ff == 64'd1) begin
                  phase_in = PH_TAG;
               end
            end
            default: begin
               // tag phase, and any unused code behaves as tag phase
               result.byte_class = CLS_TAG;
               phase_in          = PH_TAG;
               if (more) begin
                  accum_in = acc_new;
                  vcnt_in  = vcnt_inc;
                  if (vcnt_inc == VCNT_OVER) begin
                     error_in = 1'b1;
                  end
               end else begin
                  accum_in = '0;
                  vcnt_in  = '0;
                  field_in = acc_new[34:3];
                  case (acc_new[2:0])
                     WT_VARINT: phase_in = PH_SKV;
                     WT_I64: begin
                        remain_in = 64'd8;
                        phase_in  = PH_SKF;
                     end
                     WT_LEN:    phase_in = PH_LEN;
                     WT_I32: begin
                        remain_in = 64'd4;
                        phase_in  = PH_SKF;
                     end
                     default:   error_in = 1'b1;
                  endcase
               end
            end
         endcase
      end

      if (error_in) begin
         result.feed_status = ST_MALFORMED;
      end else if (phase_in != PH_TAG || vcnt_in != 4'd0) begin
         result.feed_status = ST_TRUNCATED;
      end else begin
         result.feed_status = ST_COMPLETE;
      end
      result.field_number       = field_in;
      result.entities_seen      = seen_in;
      result.entities_too_large = tl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         accum_ff  <= '0;
         vcnt_ff   <= '0;
         field_ff  <= '0;
         remain_ff <= '0;
         error_ff  <= 1'b0;
         seen_ff   <= '0;
         tl_ff     <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         vcnt_ff   <= vcnt_in;
         field_ff  <= field_in;
         remain_ff <= remain_in;
         error_ff  <= error_in;
         seen_ff   <= seen_in;
         tl_ff     <= tl_in;
      end
   end

   `PBFR_ASSERT_NXT(a_error_sticky, clock, reset, error_ff, error_ff,
                    "malformed flag cleared without reset")
   `PBFR_ASSERT_IMP(a_too_large_is_entity, clock, reset, result.entity_too_large,
                    result.entity_start, "too-large mark without entity start")
   `PBFR_ASSERT_IMP(a_last_class, clock, reset, result.body_last,
                    result.byte_class == CLS_HDR || result.byte_class == CLS_ENT ||
                    result.byte_class == CLS_LEN, "body end on a non-body byte")

endmodule

`default_nettype wire

>>> rtl/core/pbfr_out_buf.sv
// ---------------------------------------------------------------------------
// Protobuf framer output buffer
// Two-entry result buffer: output register plus skid entry.
// ---------------------------------------------------------------------------
`default_nettype none
`include "protobuf_top_level_field_framer_core_macros.svh"

module pbfr_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire pbfr_pkg::result_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output pbfr_pkg::result_type      out_data
);
   import pbfr_pkg::*;

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_data_ff;
   result_type skid_data_ff;
   logic       out_load;

   assign out_load  = !out_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff  <= skid_valid_ff || in_valid;
         skid_valid_ff <= skid_valid_ff && in_valid;
      end else if (in_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            if (in_valid) begin
               skid_data_ff <= in_data;
            end
         end else if (in_valid) begin
            out_data_ff <= in_data;
         end
      end else if (in_valid) begin
         skid_data_ff <= in_data;
      end
   end

   `PBFR_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
                    "skid entry held while output register is empty")
   `PBFR_ASSERT_NXT(a_stall_fills_skid, clock, reset,
                    in_valid && out_valid_ff && !out_ready, skid_valid_ff,
                    "transaction lost during output stall")
   `PBFR_ASSERT_NXT(a_out_held, clock, reset, out_valid_ff && !out_ready,
                    out_valid_ff && $stable(out_data_ff),
                    "output transaction changed while stalled")

endmodule

`default_nettype wire

>>> verif/protobuf_top_level_field_framer_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Protobuf top-level field framer testbench
// Streams protobuf feeds through the framer core, byte by byte, and compares
// every result with a framing model kept in the bench. Feeds mix well-formed
// fields, short bursts of random bytes and one malformed tail at the end.
// ---------------------------------------------------------------------------

module protobuf_top_level_field_framer_core_tb;
   import pbfr_pkg::*;

   // wiretypes that the framer rejects
   localparam logic [2:0] WT_SGROUP = 3'd3;
   localparam logic [2:0] WT_EGROUP = 3'd4;
   localparam logic [2:0] WT_BAD6   = 3'd6;
   localparam logic [2:0] WT_BAD7   = 3'd7;

   // framing state, grouped so that a lookahead can save and restore it
   typedef struct packed {
      phase_type   ph;
      logic [63:0] acc;
      logic [6:0]  shift;
      logic [31:0] fnum;
      logic [63:0] remaining;
      logic        malformed;
      logic [31:0] seen;
      logic [31:0] too_large;
   } framer_state_type;

   // Holds the framing model, the byte results still owed by the block and
   // the mismatch count.
   class field_frame_scoreboard;
      framer_state_type               st;
      logic [MAX_ENTITY_W-1:0]        entity_limit;
      logic [MAX_HEADER_W-1:0]        header_limit;
      result_type                     pending_byte_results[$];
      int unsigned                    mismatch_count;

      function new();
         st = '0;
         st.ph = PH_TAG;
         entity_limit = MAX_ENTITY_RST;
         header_limit = MAX_HEADER_RST;
         mismatch_count = 0;
      endfunction

      // add seven bits; high bits past bit 63 fall off
      function bit take_varint(logic [7:0] b);
         if (st.shift < 7'd64) st.acc |= {57'b0, b[6:0]} << st.shift;
         if (b[7]) begin
            st.shift += 7'd7;
            if (st.shift >= 7'd70) st.malformed = 1'b1;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // advance the framing state by one feed byte and return its result
      function result_type frame_byte(logic [7:0] b);
         result_type  r;
         logic [63:0] len;
         logic [63:0] tag;
         r = '0;
         r.byte_class = CLS_IGNORED;
         if (!st.malformed) begin
            case (st.ph)
               PH_LEN: begin
                  r.byte_class = CLS_LEN;
                  if (take_varint(b)) begin
                     len = st.acc;
                     st.acc = '0;
                     st.shift = '0;
                     if (st.fnum == FIELD_HEADER) begin
                        // empty check first, then the size limit
                        if (len == 0) begin
                           r.body_last = 1'b1;
                           r.body_empty = 1'b1;
                           st.ph = PH_TAG;
                        end else if (len > 64'(header_limit)) begin
                           st.remaining = len;
                           st.ph = PH_SKF;
                        end else begin
                           st.remaining = len;
                           st.ph = PH_HDR;
                        end
                     end else if (st.fnum == FIELD_ENTITY) begin
                        // size limit first, so an empty entity is never too large
                        st.seen += 32'd1;
                        r.entity_start = 1'b1;
                        if (len > 64'(entity_limit)) begin
                           st.too_large += 32'd1;
                           r.entity_too_large = 1'b1;
                           st.remaining = len;
                           st.ph = PH_SKF;
                        end else if (len == 0) begin
                           r.body_last = 1'b1;
                           r.body_empty = 1'b1;
                           st.ph = PH_TAG;
                        end else begin
                           st.remaining = len;
                           st.ph = PH_ENT;
                        end
                     end else if (len == 0) begin
                        st.ph = PH_TAG;
                     end else begin
                        st.remaining = len;
                        st.ph = PH_SKF;
                     end
                  end
               end
               PH_HDR, PH_ENT: begin
                  if (st.ph == PH_HDR) r.byte_class = CLS_HDR;
                  else r.byte_class = CLS_ENT;
                  r.data_byte_out = b;
                  st.remaining -= 64'd1;
                  if (st.remaining == 0) begin
                     r.body_last = 1'b1;
                     st.ph = PH_TAG;
                  end
               end
               PH_SKV: begin
                  r.byte_class = CLS_SKV;
                  if (!b[7]) st.ph = PH_TAG;
               end
               PH_SKF: begin
                  r.byte_class = CLS_SKF;
                  st.remaining -= 64'd1;
                  if (st.remaining == 0) st.ph = PH_TAG;
               end
               default: begin
                  r.byte_class = CLS_TAG;
                  st.ph = PH_TAG;
                  if (take_varint(b)) begin
                     tag = st.acc;
                     st.acc = '0;
                     st.shift = '0;
                     st.fnum = tag[34:3];
                     case (tag[2:0])
                        WT_VARINT: st.ph = PH_SKV;
                        WT_I64: begin
                           st.remaining = 64'd8;
                           st.ph = PH_SKF;
                        end
                        WT_LEN: st.ph = PH_LEN;
                        WT_I32: begin
                           st.remaining = 64'd4;
                           st.ph = PH_SKF;
                        end
                        default: st.malformed = 1'b1;
                     endcase
                  end
               end
            endcase
         end
         if (st.malformed) r.feed_status = ST_MALFORMED;
         else if (st.ph != PH_TAG || st.shift != 0 || st.acc != 0)
            r.feed_status = ST_TRUNCATED;
         else r.feed_status = ST_COMPLETE;
         r.field_number = st.fnum;
         r.entities_seen = st.seen;
         r.entities_too_large = st.too_large;
         return r;
      endfunction

      // true when the byte keeps the feed recoverable and its bodies short
      function bit byte_is_safe(logic [7:0] b);
         framer_state_type saved;
         bit               ok;
         saved = st;
         void'(frame_byte(b));
         ok = !st.malformed && st.shift <= 7'd56;
         case (st.ph)
            PH_TAG:
               if (st.shift != 0 && st.acc[2:0] != WT_VARINT && st.acc[2:0] != WT_I64 &&
                   st.acc[2:0] != WT_LEN && st.acc[2:0] != WT_I32) ok = 1'b0;
            PH_LEN: if (st.acc > 64'd600) ok = 1'b0;
            PH_HDR, PH_ENT, PH_SKF: if (st.remaining > 64'd600) ok = 1'b0;
            default: ;
         endcase
         st = saved;
         return ok;
      endfunction

      function bit at_boundary();
         return st.ph == PH_TAG && st.shift == 0 && st.acc == 0;
      endfunction

      function void note_feed_byte(logic [7:0] b);
         pending_byte_results.insert(pending_byte_results.size(), frame_byte(b));
      endfunction

      function int pending();
         return pending_byte_results.size();
      endfunction

      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            mismatch_count++;
         end
      endfunction

      function void check_byte_result(logic [2:0] cls, logic [111:0] data, logic last);
         result_type e;
         if (pending_byte_results.size() == 0) begin
            $error("byte result with no feed byte outstanding");
            mismatch_count++;
            return;
         end
         e = pending_byte_results.pop_front();
         compare_field("byte_class", 32'(e.byte_class), 32'(cls));
         compare_field("data_byte_out", 32'(e.data_byte_out), 32'(data[7:0]));
         compare_field("field_number", e.field_number, data[39:8]);
         compare_field("body_last", 32'(e.body_last), 32'(last));
         compare_field("body_empty", 32'(e.body_empty), 32'(data[40]));
         compare_field("entity_start", 32'(e.entity_start), 32'(data[41]));
         compare_field("entity_too_large", 32'(e.entity_too_large), 32'(data[42]));
         compare_field("feed_status", 32'(e.feed_status), 32'(data[44:43]));
         compare_field("entities_seen", e.entities_seen, data[76:45]);
         compare_field("entities_too_large", e.entities_too_large, data[108:77]);
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;    // [7:0] data_byte
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [111:0]  rsp_tdata;    // [7:0] data_byte_out .. [108:77] entities_too_large
   logic [2:0]    rsp_tuser;    // [2:0] byte_class
   logic          rsp_tlast;    // body_last
   logic          csr_we;
   logic          csr_addr;
   logic [MAX_ENTITY_W-1:0] csr_wdata;

   field_frame_scoreboard sb = new();

   logic [7:0]  feed_bytes[$];   // bytes waiting to be offered
   bit          no_idle = 1'b0;  // suppress random gaps on both sides
   int unsigned rx_holdoff = 0;  // cycles for the receiver to hold off

   // Short directed feed under the reset limits: empty and two-byte header,
   // empty and one-byte entity, a fixed32 field, a varint field with field
   // number zero, and unknown length-delimited fields of zero and one byte.
   logic [7:0] directed_feed [24] = '{
      8'h0A, 8'h00,
      8'h0A, 8'h02, 8'h00, 8'hFF,
      8'h12, 8'h00,
      8'h12, 8'h01, 8'hA5,
      8'h1D, 8'h11, 8'h22, 8'h33, 8'h44,
      8'h00, 8'hFF, 8'h01,
      8'h1A, 8'h00,
      8'h22, 8'h01, 8'h77
   };

   protobuf_top_level_field_framer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Note accepted feed bytes and check results on the same edge, so the
   // order of the two handshakes within a time step cannot matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_feed_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_byte_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: random stalls, none while no_idle is set, and a counted
   // hold-off when one is requested.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_holdoff > 0) begin
            rsp_tready <= 1'b0;
            rx_holdoff--;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // Queue one byte at the end of the feed.
   function void append_byte(logic [7:0] b);
      feed_bytes.insert(feed_bytes.size(), b);
   endfunction

   // Emit a varint; padding adds redundant continuation bytes (ten at most)
   // and junk fills the bits of a tenth byte that fall past bit 63.
   function void push_varint(logic [63:0] v, int pad, bit junk);
      int          n;
      int          total;
      logic [63:0] t;
      logic [7:0]  b;
      n = 1;
      t = v >> 7;
      while (t != 0) begin
         n++;
         t = t >> 7;
      end
      total = n + pad;
      if (total > 10) total = 10;
      for (int i = 0; i < total; i++) begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (i < total - 1) b[7] = 1'b1;
         else if (i == 9 && junk) b[6:1] = 6'($urandom_range(0, 63));
         append_byte(b);
      end
   endfunction

   function logic [31:0] pick_field_number();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'd0;
      if (r == 1) return 32'hFFFF_FFFF;
      if (r < 5) return $urandom;
      return $urandom_range(3, 40);
   endfunction

   // Mostly short bodies; now and then right at or just past the limit.
   function logic [63:0] pick_length(logic [31:0] limit);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10 && limit <= 299) return 64'(limit) + 64'($urandom_range(0, 1));
      if (r < 25) return 64'd0;
      if (r < 60) return 64'($urandom_range(1, 8));
      if (r < 90) return 64'($urandom_range(9, 40));
      return 64'($urandom_range(41, 300));
   endfunction

   // Append one complete, well-formed top-level field with random content.
   function void add_field();
      int          r;
      int          n;
      logic [2:0]  wt;
      logic [31:0] fnum;
      logic [63:0] tag;
      logic [63:0] len;
      r = $urandom_range(0, 99);
      fnum = pick_field_number();
      if (r < 12) wt = WT_VARINT;
      else if (r < 22) wt = WT_I64;
      else if (r < 32) wt = WT_I32;
      else wt = WT_LEN;
      if (r >= 32 && r < 60) fnum = FIELD_HEADER;
      else if (r >= 60 && r < 90) fnum = FIELD_ENTITY;
      else if (r >= 90) begin
         while (fnum == FIELD_HEADER || fnum == FIELD_ENTITY) fnum = pick_field_number();
      end
      tag = {29'b0, fnum, wt};
      // bits above the 32-bit field number must drop out
      if ($urandom_range(0, 9) == 0) tag[63:35] = 29'({$urandom, $urandom});
      push_varint(tag, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0,
                  1'($urandom_range(0, 1)));
      case (wt)
         WT_VARINT: begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n - 1; i++) begin
               append_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            append_byte(8'($urandom_range(0, 127)));
         end
         WT_I64: repeat (8) append_byte(8'($urandom));
         WT_I32: repeat (4) append_byte(8'($urandom));
         default: begin
            if (fnum == FIELD_HEADER) len = pick_length(32'(sb.header_limit));
            else len = pick_length(32'(sb.entity_limit));
            push_varint(len, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0,
                        1'($urandom_range(0, 1)));
            for (int i = 0; i < len; i++) append_byte(8'($urandom));
         end
      endcase
   endfunction

   // A burst of random bytes that cut into fields anywhere, kept clear of a
   // malformed feed, then bytes to bring the feed back to a field boundary.
   function void add_noise();
      field_frame_scoreboard g;
      logic [7:0]            b;
      int                    k;
      int                    tries;
      g = new();
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
         tries = 0;
         do begin
            b = 8'($urandom);
            tries++;
         end while (!g.byte_is_safe(b) && tries < 50);
         if (!g.byte_is_safe(b)) break;
         void'(g.frame_byte(b));
         append_byte(b);
      end
      while (!g.at_boundary()) begin
         if (g.st.ph == PH_HDR || g.st.ph == PH_ENT || g.st.ph == PH_SKF) b = 8'($urandom);
         else b = 8'h00;
         void'(g.frame_byte(b));
         append_byte(b);
      end
   endfunction

   function void fill_random(int unsigned n);
      int unsigned stop_at;
      stop_at = feed_bytes.size() + n;
      while (feed_bytes.size() < stop_at) begin
         if ($urandom_range(0, 99) < 12) add_noise();
         else add_field();
      end
   endfunction

   // One way to break the feed (the error is sticky), then bytes to be ignored.
   function void add_malformed_tail();
      logic [2:0] bad_wt;
      case ($urandom_range(0, 2))
         0: begin
            // overlong tag varint
            repeat (10) append_byte(8'h80 | 8'($urandom_range(0, 127)));
         end
         1: begin
            // overlong length varint
            push_varint({29'b0, pick_field_number(), WT_LEN}, 0, 1'b0);
            repeat (10) append_byte(8'h80 | 8'($urandom_range(0, 127)));
         end
         default: begin
            // group or reserved wiretype
            case ($urandom_range(0, 3))
               0: bad_wt = WT_SGROUP;
               1: bad_wt = WT_EGROUP;
               2: bad_wt = WT_BAD6;
               default: bad_wt = WT_BAD7;
            endcase
            push_varint({29'b0, pick_field_number(), bad_wt}, 0, 1'b0);
         end
      endcase
      repeat (16) append_byte(8'($urandom));
   endfunction

   // Offer every queued byte: set up at the falling edge, hold until taken.
   task automatic send_feed();
      logic [7:0] b;
      while (feed_bytes.size() > 0) begin
         b = feed_bytes.pop_front();
         @(negedge clock);
         while (!no_idle && $urandom_range(0, 99) < 16) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= b;
         do @(posedge clock); while (!req_tready);
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Write both limits while nothing is in flight, and mirror them.
   task automatic write_limits(logic [MAX_ENTITY_W-1:0] ent, logic [MAX_HEADER_W-1:0] hdr);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MAX_ENTITY;
      csr_wdata <= ent;
      @(negedge clock);
      csr_addr  <= CSR_MAX_HEADER;
      csr_wdata <= {{(MAX_ENTITY_W - MAX_HEADER_W){1'b0}}, hdr};
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.entity_limit = ent;
      sb.header_limit = hdr;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = CSR_MAX_ENTITY;
      csr_wdata  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits: directed feed, then random fields
      foreach (directed_feed[i]) append_byte(directed_feed[i]);
      fill_random(115);
      send_feed();
      wait_drained();

      for (int p = 1; p < 6; p++) begin
         case (p)
            1: write_limits('0, '0);
            2: write_limits('1, '1);
            3: write_limits(20'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
            4: write_limits(20'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
            default: write_limits(20'($urandom), 16'($urandom));
         endcase
         // one phase with no gaps at all; one where the receiver holds off
         // long enough for the block to fill and stall its input
         no_idle = (p == 2);
         if (p == 3) rx_holdoff = 300;
         fill_random(115);
         send_feed();
         wait_drained();
      end

      no_idle = 1'b0;
      add_malformed_tail();
      send_feed();
      wait_drained();
      repeat (8) @(posedge clock);

      if (sb.mismatch_count == 0) begin
         $display("[protobuf_top_level_field_framer_core] OK");
      end else begin
         $display("[protobuf_top_level_field_framer_core] ERROR");
      end
      $finish;
   end

   // Run limit: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("[protobuf_top_level_field_framer_core] ERROR");
      $finish;
   end

endmodule
